// ===== rtl/rss_pkg.sv =====
// shared types and constants of the rms silence segmenter
package rss_pkg;

  // fixed field widths
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned ENERGY_W    = 2 * SAMPLE_W;
  localparam int unsigned IDX_W       = 32;
  localparam int unsigned LEN_CFG_W   = 11;
  localparam int unsigned THR_W       = 31;
  localparam int unsigned MIN_SIL_W   = 24;
  localparam int unsigned LANE_CFG_W  = 2;
  localparam int unsigned RUN_W       = 25;
  localparam int unsigned CFG_DATA_W  = 31;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned MAX_RESULTS = 5;
  localparam int unsigned RES_CNT_W   = 3;

  // register reset values
  localparam logic [LEN_CFG_W-1:0]  WLEN_RST    = 11'd1024;
  localparam logic [LEN_CFG_W-1:0]  HOP_RST     = 11'd256;
  localparam logic [THR_W-1:0]      THR_RST     = 31'd1073;
  localparam logic [MIN_SIL_W-1:0]  MIN_SIL_RST = 24'd22050;
  localparam logic [LANE_CFG_W-1:0] LANES_RST   = 2'd2;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH       = 3'd0,
    CFG_HOP_LENGTH          = 3'd1,
    CFG_THRESHOLD_ENERGY    = 3'd2,
    CFG_MIN_SILENCE_SAMPLES = 3'd3,
    CFG_CHANNELS_IN_USE     = 3'd4
  } cfg_idx_e;

  // input beat
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_first_channel;
    logic signed [SAMPLE_W-1:0] sample_second_channel;
    logic                       end_of_buffer;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic [IDX_W-1:0] segment_start;
    logic [IDX_W-1:0] segment_length;
    logic             last_in_run;
  } out_beat_t;

endpackage

// ===== rtl/rss_window_mem.sv =====
// window memory: start index and energy snapshot of each window in flight
module rss_window_mem #(
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned ADDR_W = 3,
  parameter int unsigned DATA_W = 74
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rss_energy.sv =====
// frame energy: squared samples of the lanes in use, registered on the input beat
module rss_energy (
  input  logic                               clk_i,
  input  logic                               load_i,
  input  logic signed [rss_pkg::SAMPLE_W-1:0] sample_a_i,
  input  logic signed [rss_pkg::SAMPLE_W-1:0] sample_b_i,
  input  logic                               two_lanes_i,
  output logic [rss_pkg::ENERGY_W-1:0]       energy_o
);
  import rss_pkg::*;

  logic signed [ENERGY_W-1:0] sq_a;
  logic signed [ENERGY_W-1:0] sq_b;
  logic [ENERGY_W-1:0]        energy_d;
  logic [ENERGY_W-1:0]        energy_q;

  // squares are never negative, at most two to the power of thirty
  assign sq_a = sample_a_i * sample_a_i;
  assign sq_b = sample_b_i * sample_b_i;

  assign energy_d = $unsigned(sq_a) + (two_lanes_i ? $unsigned(sq_b) : '0);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      energy_q <= energy_d;
    end
  end

  assign energy_o = energy_q;

endmodule

// ===== rtl/rms_silence_segmenter.sv =====
// top level of the rms silence segmenter
//
// Usage: one stereo or mono audio frame per input beat on in_valid_i/in_ready_o,
// end_of_buffer set on the last frame of a buffer. Each segment found, up to five
// per frame, comes out as one beat on out_valid_o/out_ready_i; last_in_run marks
// the final segment caused by a frame. Registers are to be written through
// cfg_we_i/cfg_idx_i/cfg_data_i only while the block is idle; the user must keep
// to this, the block itself does not enforce it. A new frame is taken only when
// the sequencer is back in idle, after the previous frame is done. The single read
// port of the window memory has windows retired one at a time, oldest first.
// A segment is held one step back so that last_in_run can be known; it reaches
// the output register when the next segment is found or when the frame finishes,
// in either case once the output register is free.
// Reset clears all counters, the window ring and the output; registers go to
// their defaults. A stalled receiver holds the output register; the block then
// waits before handing over a second segment and takes no new frame until all
// segments of the current one have moved on.
module rms_silence_segmenter #(
  parameter int unsigned MAX_WINDOW  = 1024,
  parameter int unsigned MAX_OVERLAP = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  rss_pkg::in_beat_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output rss_pkg::out_beat_t                 out_data_o,
  input  logic                               cfg_we_i,
  input  logic [rss_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rss_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import rss_pkg::*;

  localparam int unsigned PTR_W   = (MAX_OVERLAP > 1) ? $clog2(MAX_OVERLAP) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_OVERLAP + 1);
  localparam int unsigned LEN_W   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W   = ENERGY_W + $clog2(MAX_WINDOW);
  localparam int unsigned LCNT_W  = LEN_W + 1;
  localparam int unsigned PROD_W  = THR_W + LCNT_W;
  localparam int unsigned CMP_W   = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int unsigned MEM_W   = IDX_W + SUM_W;

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_EVAL = 3'd3;
  localparam logic [2:0] ST_RET  = 3'd4;
  localparam logic [2:0] ST_EOB  = 3'd5;
  localparam logic [2:0] ST_END  = 3'd6;

  // registers
  logic [LEN_CFG_W-1:0]  wlen_q;
  logic [LEN_CFG_W-1:0]  hop_q;
  logic [THR_W-1:0]      thr_q;
  logic [MIN_SIL_W-1:0]  min_sil_q;
  logic [LANE_CFG_W-1:0] lanes_q;

  // sequencer and segment state
  logic [2:0]           state_q, state_d;
  logic [IDX_W-1:0]     fi_q, fi_d;
  logic [IDX_W-1:0]     nws_q, nws_d;
  logic [PTR_W-1:0]     head_q, head_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [SUM_W-1:0]     cum_q, cum_d;
  logic                 seg_open_q, seg_open_d;
  logic [IDX_W-1:0]     open_start_q, open_start_d;
  logic [RUN_W-1:0]     run_q, run_d;
  logic                 eob_q, eob_d;
  logic [RES_CNT_W-1:0] nres_q, nres_d;
  logic                 pend_valid_q, pend_valid_d;
  logic [IDX_W-1:0]     pend_start_q, pend_start_d;
  logic [IDX_W-1:0]     pend_len_q, pend_len_d;
  logic                 out_valid_q, out_valid_d;
  out_beat_t            out_q, out_d;
  logic [IDX_W-1:0]     ws_q, ws_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [PROD_W-1:0]    prod_q, prod_d;

  // datapath
  logic                 in_fire;
  logic                 two_lanes;
  logic [ENERGY_W-1:0]  energy;
  logic [LEN_CFG_W-1:0] wl_eff;
  logic [LEN_CFG_W-1:0] hop_eff;
  logic [PTR_W:0]       tail_sum;
  logic [PTR_W-1:0]     tail;
  logic [PTR_W-1:0]     head_inc;
  logic [IDX_W:0]       nws_sum;
  logic [RUN_W:0]       run_sum;
  logic [RUN_W-1:0]     run_new;
  logic [IDX_W-1:0]     num;
  logic [IDX_W-1:0]     ws_rd;
  logic [SUM_W-1:0]     snap_rd;
  logic [IDX_W-1:0]     diff_rd;
  logic                 qualify;
  logic [LEN_W-1:0]     len_rd;
  logic [LCNT_W-1:0]    lane_cnt;
  logic [PROD_W-1:0]    prod_rd;
  logic                 silent;
  logic                 emit_req;
  logic [IDX_W-1:0]     emit_start;
  logic [IDX_W-1:0]     emit_len;
  logic                 emit_take;
  logic                 out_free;
  logic                 emit_stall;
  logic                 emit_fire;

  // memory port
  logic                 mem_we;
  logic [MEM_W-1:0]     mem_wdata;
  logic                 mem_re;
  logic [MEM_W-1:0]     mem_rdata;

  function automatic logic [LEN_CFG_W-1:0] eff_len(input logic [LEN_CFG_W-1:0] v);
    logic [LEN_CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = LEN_CFG_W'(1);
    end else if (32'(v) > 32'(MAX_WINDOW)) begin
      r = LEN_CFG_W'(MAX_WINDOW);
    end
    return r;
  endfunction

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q    <= WLEN_RST;
      hop_q     <= HOP_RST;
      thr_q     <= THR_RST;
      min_sil_q <= MIN_SIL_RST;
      lanes_q   <= LANES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW_LENGTH:       wlen_q    <= cfg_data_i[LEN_CFG_W-1:0];
        CFG_HOP_LENGTH:          hop_q     <= cfg_data_i[LEN_CFG_W-1:0];
        CFG_THRESHOLD_ENERGY:    thr_q     <= cfg_data_i[THR_W-1:0];
        CFG_MIN_SILENCE_SAMPLES: min_sil_q <= cfg_data_i[MIN_SIL_W-1:0];
        CFG_CHANNELS_IN_USE:     lanes_q   <= cfg_data_i[LANE_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign wl_eff    = eff_len(wlen_q);
  assign hop_eff   = eff_len(hop_q);
  assign two_lanes = lanes_q[1];

  // frame energy unit
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  rss_energy u_energy (
    .clk_i       (clk_i),
    .load_i      (in_fire),
    .sample_a_i  (in_data_i.sample_first_channel),
    .sample_b_i  (in_data_i.sample_second_channel),
    .two_lanes_i (two_lanes),
    .energy_o    (energy)
  );

  // ring pointers
  assign tail_sum = (PTR_W + 1)'(head_q) + (PTR_W + 1)'(cnt_q);
  assign tail     = (tail_sum >= (PTR_W + 1)'(MAX_OVERLAP))
                    ? PTR_W'(tail_sum - (PTR_W + 1)'(MAX_OVERLAP)) : PTR_W'(tail_sum);
  assign head_inc = (head_q == PTR_W'(MAX_OVERLAP - 1)) ? '0 : head_q + 1'b1;

  // saturating counters
  assign nws_sum = {1'b0, nws_q} + (IDX_W + 1)'(hop_eff);
  assign run_sum = {1'b0, run_q} + (RUN_W + 1)'(hop_eff);
  assign run_new = run_sum[RUN_W] ? '1 : run_sum[RUN_W-1:0];
  assign num     = (fi_q == '1) ? fi_q : fi_q + 1'b1;

  // window memory, a new window keeps the running energy total at its start
  assign mem_wdata = {fi_q, cum_q};

  rss_window_mem #(
    .DEPTH  (MAX_OVERLAP),
    .ADDR_W (PTR_W),
    .DATA_W (MEM_W)
  ) u_window_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tail),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (head_q),
    .rdata_o (mem_rdata)
  );

  // oldest window: age check, energy and threshold product
  assign ws_rd    = mem_rdata[MEM_W-1 -: IDX_W];
  assign snap_rd  = mem_rdata[SUM_W-1:0];
  assign diff_rd  = fi_q - ws_rd;
  assign qualify  = eob_q || (diff_rd >= (IDX_W'(wl_eff) - IDX_W'(1)));
  assign len_rd   = LEN_W'(diff_rd) + LEN_W'(1);
  assign lane_cnt = two_lanes ? {len_rd, 1'b0} : {1'b0, len_rd};
  assign prod_rd  = thr_q * lane_cnt;
  assign silent   = CMP_W'(sum_q) < CMP_W'(prod_q);

  // segment found in this cycle
  always_comb begin
    emit_req   = 1'b0;
    emit_start = open_start_q;
    emit_len   = ws_q - open_start_q;
    unique case (state_q)
      ST_RET: begin
        emit_req = silent && seg_open_q && (run_new >= RUN_W'(min_sil_q));
      end
      ST_EOB: begin
        emit_req = seg_open_q;
        emit_len = num - open_start_q;
      end
      default: ;
    endcase
  end

  // a held segment moves to the output register when the next one arrives
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit_take  = emit_req && (nres_q < RES_CNT_W'(MAX_RESULTS));
  assign emit_stall = emit_take && pend_valid_q && !out_free;
  assign emit_fire  = emit_take && !emit_stall;

  // sequencer
  always_comb begin
    state_d      = state_q;
    fi_d         = fi_q;
    nws_d        = nws_q;
    head_d       = head_q;
    cnt_d        = cnt_q;
    cum_d        = cum_q;
    seg_open_d   = seg_open_q;
    open_start_d = open_start_q;
    run_d        = run_q;
    eob_d        = eob_q;
    nres_d       = nres_q;
    pend_valid_d = pend_valid_q;
    pend_start_d = pend_start_q;
    pend_len_d   = pend_len_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    ws_d         = ws_q;
    sum_d        = sum_q;
    prod_d       = prod_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          eob_d   = in_data_i.end_of_buffer;
          nres_d  = '0;
          state_d = ST_UPD;
        end
      end
      // open a window when one is due and a ring slot is free, add the frame to the running total
      ST_UPD: begin
        if (fi_q == nws_q) begin
          nws_d = nws_sum[IDX_W] ? '1 : nws_sum[IDX_W-1:0];
          if (cnt_q < CNT_W'(MAX_OVERLAP)) begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + 1'b1;
          end
        end
        cum_d   = cum_q + SUM_W'(energy);
        state_d = ST_RD;
      end
      ST_RD: begin
        if (cnt_q != '0) begin
          mem_re  = 1'b1;
          state_d = ST_EVAL;
        end else if (eob_q) begin
          state_d = ST_EOB;
        end else begin
          state_d = ST_END;
        end
      end
      ST_EVAL: begin
        if (qualify) begin
          ws_d    = ws_rd;
          sum_d   = cum_q - snap_rd;
          prod_d  = prod_rd;
          state_d = ST_RET;
        end else begin
          state_d = ST_END;
        end
      end
      // retire the oldest window and update the segment state
      ST_RET: begin
        if (!emit_stall) begin
          if (!silent) begin
            if (!seg_open_q) begin
              seg_open_d   = 1'b1;
              open_start_d = ws_q;
            end
            run_d = '0;
          end else if (seg_open_q) begin
            run_d = run_new;
            if (run_new >= RUN_W'(min_sil_q)) begin
              seg_open_d = 1'b0;
            end
          end
          head_d  = head_inc;
          cnt_d   = cnt_q - 1'b1;
          state_d = ST_RD;
        end
      end
      ST_EOB: begin
        if (!emit_stall) begin
          state_d = ST_END;
        end
      end
      // hand over the held segment as last of the frame, then advance
      ST_END: begin
        if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_valid_d             = 1'b1;
            out_d.segment_start     = pend_start_q;
            out_d.segment_length    = pend_len_q;
            out_d.last_in_run       = 1'b1;
            pend_valid_d            = 1'b0;
          end
          if (eob_q) begin
            fi_d         = '0;
            nws_d        = '0;
            head_d       = '0;
            cnt_d        = '0;
            seg_open_d   = 1'b0;
            open_start_d = '0;
            run_d        = '0;
          end else if (fi_q != '1) begin
            fi_d = fi_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // segment capture
    if (emit_fire) begin
      if (pend_valid_q) begin
        out_valid_d          = 1'b1;
        out_d.segment_start  = pend_start_q;
        out_d.segment_length = pend_len_q;
        out_d.last_in_run    = 1'b0;
      end
      pend_valid_d = 1'b1;
      pend_start_d = emit_start;
      pend_len_d   = emit_len;
      nres_d       = nres_q + 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fi_q         <= '0;
      nws_q        <= '0;
      head_q       <= '0;
      cnt_q        <= '0;
      cum_q        <= '0;
      seg_open_q   <= 1'b0;
      open_start_q <= '0;
      run_q        <= '0;
      eob_q        <= 1'b0;
      nres_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fi_q         <= fi_d;
      nws_q        <= nws_d;
      head_q       <= head_d;
      cnt_q        <= cnt_d;
      cum_q        <= cum_d;
      seg_open_q   <= seg_open_d;
      open_start_q <= open_start_d;
      run_q        <= run_d;
      eob_q        <= eob_d;
      nres_q       <= nres_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    pend_start_q <= pend_start_d;
    pend_len_q   <= pend_len_d;
    out_q        <= out_d;
    ws_q         <= ws_d;
    sum_q        <= sum_d;
    prod_q       <= prod_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== dv/tb.sv =====
// testbench of the rms silence segmenter: frame stimulus, segment prediction and checking
module tb;
  import rss_pkg::*;

  localparam int unsigned RING_DEPTH   = 8;
  localparam int unsigned SPAN_MAX     = 1024;
  localparam int unsigned MAX_SEGS     = 5;
  localparam int unsigned QUIET_MAX    = 200;
  localparam int unsigned LOUD_MIN     = 2000;
  localparam int unsigned SETTLE_CYC   = 64;
  localparam int unsigned HOLD_CYC     = 400;
  localparam int unsigned RAND_FRAMES  = 170;
  localparam longint      RUN_LIMIT    = 64'd20_000_000;
  localparam bit [24:0]   RUN_SAT      = 25'h1FFFFFF;
  localparam int          BURST_SAMPLES [9] = '{32767, 0, 141, 0, 141, 0, 124, 0, 122};

  // segment predictor and store of expected segment beats
  class segment_scoreboard;
    bit [LEN_CFG_W-1:0]  win_len;
    bit [LEN_CFG_W-1:0]  hop_len;
    bit [THR_W-1:0]      thr;
    bit [MIN_SIL_W-1:0]  min_sil;
    bit [LANE_CFG_W-1:0] lane_cfg;

    longint unsigned energy_acc [RING_DEPTH];
    bit [IDX_W-1:0]  win_start [RING_DEPTH];
    int unsigned     ring_head;
    int unsigned     ring_fill;
    bit [IDX_W-1:0]  frame_idx;
    bit [IDX_W-1:0]  next_start;
    bit              seg_open;
    bit [IDX_W-1:0]  open_start;
    bit [RUN_W-1:0]  silent_run;
    int unsigned     step_segs;

    out_beat_t   expected_q [$];
    int unsigned n_checked;
    int unsigned n_errors;

    function new();
      win_len  = WLEN_RST;
      hop_len  = HOP_RST;
      thr      = THR_RST;
      min_sil  = MIN_SIL_RST;
      lane_cfg = LANES_RST;
      n_checked = 0;
      n_errors  = 0;
      clear_state();
    endfunction

    function void clear_state();
      for (int i = 0; i < RING_DEPTH; i++) begin
        energy_acc[i] = 0;
        win_start[i]  = 0;
      end
      ring_head  = 0;
      ring_fill  = 0;
      frame_idx  = 0;
      next_start = 0;
      seg_open   = 1'b0;
      open_start = 0;
      silent_run = 0;
    endfunction

    function void set_reg(input cfg_idx_e idx, input bit [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_WINDOW_LENGTH:       win_len  = val[LEN_CFG_W-1:0];
        CFG_HOP_LENGTH:          hop_len  = val[LEN_CFG_W-1:0];
        CFG_THRESHOLD_ENERGY:    thr      = val[THR_W-1:0];
        CFG_MIN_SILENCE_SAMPLES: min_sil  = val[MIN_SIL_W-1:0];
        CFG_CHANNELS_IN_USE:     lane_cfg = val[LANE_CFG_W-1:0];
        default: ;
      endcase
    endfunction

    // zero acts as one, oversize clamps to the longest window
    function int unsigned eff_len(input bit [LEN_CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > SPAN_MAX) return SPAN_MAX;
      return v;
    endfunction

    function int unsigned lane_count();
      return (lane_cfg >= 2) ? 2 : 1;
    endfunction

    function longint unsigned square(input logic signed [SAMPLE_W-1:0] s);
      longint m;
      m = s;
      if (m < 0) m = -m;
      return m * m;
    endfunction

    // at most five segments per frame, the rest are dropped
    function void note_segment(input bit [IDX_W-1:0] start, input bit [IDX_W-1:0] length);
      out_beat_t seg;
      if (step_segs >= MAX_SEGS) return;
      seg.segment_start  = start;
      seg.segment_length = length;
      seg.last_in_run    = 1'b0;
      expected_q.insert(expected_q.size(), seg);
      step_segs++;
    endfunction

    // judge the oldest window in flight and drop it from the ring
    function void retire_oldest();
      bit [IDX_W-1:0]  ws;
      longint unsigned span;
      longint unsigned need;
      bit              quiet;
      bit [RUN_W:0]    run_sum;
      ws    = win_start[ring_head];
      span  = {32'd0, frame_idx} - {32'd0, ws} + 64'd1;
      need  = span * lane_count();
      quiet = energy_acc[ring_head] < {33'd0, thr} * need;
      ring_head = (ring_head + 1) % RING_DEPTH;
      ring_fill--;
      if (!quiet) begin
        if (!seg_open) begin
          seg_open   = 1'b1;
          open_start = ws;
        end
        silent_run = 0;
      end else if (seg_open) begin
        run_sum    = (RUN_W + 1)'(silent_run) + (RUN_W + 1)'(eff_len(hop_len));
        silent_run = (run_sum > RUN_SAT) ? RUN_SAT : run_sum[RUN_W-1:0];
        if (silent_run >= min_sil) begin
          note_segment(open_start, ws - open_start);
          seg_open = 1'b0;
        end
      end
    endfunction

    // one accepted frame: update windows and queue the segments it causes
    function void note_frame(input in_beat_t b);
      longint unsigned e;
      longint unsigned nx;
      longint unsigned total;
      bit [IDX_W-1:0]  num;
      int unsigned     wl;
      int unsigned     slot;
      step_segs = 0;
      wl = eff_len(win_len);

      // open a window on a hop boundary if a ring slot is free
      if (frame_idx == next_start) begin
        if (ring_fill < RING_DEPTH) begin
          slot = (ring_head + ring_fill) % RING_DEPTH;
          energy_acc[slot] = 0;
          win_start[slot]  = frame_idx;
          ring_fill++;
        end
        nx = {32'd0, next_start} + eff_len(hop_len);
        next_start = (nx > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nx[IDX_W-1:0];
      end

      e = square(b.sample_first_channel);
      if (lane_count() >= 2) e += square(b.sample_second_channel);
      for (int i = 0; i < ring_fill; i++)
        energy_acc[(ring_head + i) % RING_DEPTH] += e;

      // retire every window that has seen its full length
      for (int i = 0; i < RING_DEPTH && ring_fill > 0; i++) begin
        if ({32'd0, frame_idx} - {32'd0, win_start[ring_head]} + 64'd1 < wl) break;
        retire_oldest();
      end

      // final frame flushes the ring and any open segment
      if (b.end_of_buffer) begin
        total = {32'd0, frame_idx} + 64'd1;
        num   = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[IDX_W-1:0];
        while (ring_fill > 0) retire_oldest();
        if (seg_open) note_segment(open_start, num - open_start);
        clear_state();
      end else if (frame_idx != 32'hFFFF_FFFF) begin
        frame_idx++;
      end

      // mark the final segment of this frame
      if (step_segs > 0) begin
        expected_q[expected_q.size() - 1].last_in_run = 1'b1;
      end
    endfunction

    function void check_segment(input out_beat_t got);
      out_beat_t want;
      n_checked++;
      if (expected_q.size() == 0) begin
        $error("unexpected segment beat: start %0d length %0d last %0b",
               got.segment_start, got.segment_length, got.last_in_run);
        n_errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.segment_start !== want.segment_start) begin
        $error("segment_start: expected %0d, actual %0d", want.segment_start, got.segment_start);
        n_errors++;
      end
      if (got.segment_length !== want.segment_length) begin
        $error("segment_length: expected %0d, actual %0d",
               want.segment_length, got.segment_length);
        n_errors++;
      end
      if (got.last_in_run !== want.last_in_run) begin
        $error("last_in_run: expected %0b, actual %0b", want.last_in_run, got.last_in_run);
        n_errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_beat_t              in_data_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_beat_t             out_data_o;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  segment_scoreboard sb;
  int unsigned send_idle_pct = 15;
  int unsigned recv_idle_pct = 61;
  int unsigned frames_sent   = 0;
  bit          hold_req      = 1'b0;

  rms_silence_segmenter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random back-pressure, with one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: accepted beats on both channels
  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (in_valid_i && in_ready_o) sb.note_frame(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_segment(out_data_o);
    end
  end

  // offer one frame beat, entered and left at a falling edge
  task automatic send_frame(input in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    frames_sent++;
    // idle pattern: sender light first, then receiver light, then none
    if (frames_sent == 70) begin
      send_idle_pct = 61;
      recv_idle_pct = 15;
    end else if (frames_sent == 140) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // drain all expected segments and let the block finish its last frame
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input bit [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_settings(input bit [LEN_CFG_W-1:0] wl, input bit [LEN_CFG_W-1:0] hop,
                                input bit [THR_W-1:0] thr, input bit [MIN_SIL_W-1:0] ms,
                                input bit [LANE_CFG_W-1:0] ln);
    wait_idle();
    put_reg(CFG_WINDOW_LENGTH, wl);
    put_reg(CFG_HOP_LENGTH, hop);
    put_reg(CFG_THRESHOLD_ENERGY, thr);
    put_reg(CFG_MIN_SILENCE_SAMPLES, ms);
    put_reg(CFG_CHANNELS_IN_USE, ln);
    cfg_we_i <= 1'b0;
  endtask

  // loud or quiet sample with random sign, sometimes plain noise
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input bit loud);
    int unsigned mag;
    logic signed [SAMPLE_W-1:0] s;
    if ($urandom_range(99) < 8) return SAMPLE_W'($urandom);
    mag = loud ? $urandom_range(LOUD_MIN, 32768) : $urandom_range(0, QUIET_MAX);
    s = mag[SAMPLE_W-1:0];
    if ($urandom_range(1)) s = -s;
    return s;
  endfunction

  // one buffer of alternating loud and quiet runs, with rare early ends
  task automatic send_buffer(input int unsigned len);
    in_beat_t    b;
    bit          loud;
    int unsigned run_left;
    loud = 1'($urandom_range(1));
    run_left = 0;
    for (int unsigned k = 0; k < len; k++) begin
      if (run_left == 0) begin
        loud = !loud;
        run_left = loud ? $urandom_range(1, 12) : $urandom_range(1, 24);
      end
      run_left--;
      b.sample_first_channel  = pick_sample(loud);
      b.sample_second_channel = pick_sample(loud);
      b.end_of_buffer = (k == len - 1) || ($urandom_range(99) < 2);
      send_frame(b);
    end
  endtask

  initial begin
    bit [LEN_CFG_W-1:0]  wl;
    bit [LEN_CFG_W-1:0]  hop;
    bit [THR_W-1:0]      thr;
    bit [MIN_SIL_W-1:0]  ms;
    bit [LANE_CFG_W-1:0] ln;
    int unsigned         base_frames;
    sb = new();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings, full-scale samples on both lanes
    send_frame(in_beat_t'{16'sd32767, 16'sh8000, 1'b0});
    send_frame(in_beat_t'{16'sh8000, 16'sd32767, 1'b0});
    send_frame(in_beat_t'{16'sd1, -16'sd1, 1'b1});

    // zero window and hop act as one, lane code zero is one lane
    apply_settings(11'd0, 11'd0, 31'd100, 24'd0, 2'd0);
    send_frame(in_beat_t'{16'sd500, 16'sd0, 1'b0});
    send_frame(in_beat_t'{16'sd5, 16'sd0, 1'b0});
    send_frame(in_beat_t'{16'sd0, 16'sd32767, 1'b0});
    send_frame(in_beat_t'{-16'sd500, 16'sd0, 1'b1});

    // oversize window and hop clamp, lane code three is two lanes
    apply_settings(11'd2047, 11'd2047, 31'd1000, 24'd0, 2'd3);
    send_frame(in_beat_t'{16'sd0, 16'sd0, 1'b0});
    send_frame(in_beat_t'{16'sd0, 16'sd0, 1'b0});
    send_frame(in_beat_t'{16'sd100, 16'sd100, 1'b1});

    // zero threshold: nothing is ever silent
    apply_settings(11'd2, 11'd1, 31'd0, 24'd0, 2'd2);
    send_frame(in_beat_t'{16'sd0, 16'sd0, 1'b0});
    send_frame(in_beat_t'{16'sd0, 16'sd0, 1'b0});
    send_frame(in_beat_t'{16'sd0, 16'sd0, 1'b1});

    // threshold equal to a full-scale square, then the largest threshold
    apply_settings(11'd1, 11'd1, 31'h4000_0000, 24'd0, 2'd1);
    send_frame(in_beat_t'{16'sh8000, 16'sd0, 1'b0});
    send_frame(in_beat_t'{16'sd32767, 16'sd0, 1'b0});
    send_frame(in_beat_t'{16'sh8000, 16'sd0, 1'b1});
    apply_settings(11'd1, 11'd1, 31'h7FFF_FFFF, 24'hFFFFFF, 2'd1);
    send_frame(in_beat_t'{16'sh8000, 16'sh8000, 1'b0});
    send_frame(in_beat_t'{16'sh8000, 16'sh8000, 1'b1});

    // full ring flushed on the last frame: five segments from one frame
    apply_settings(11'd8, 11'd1, 31'd10000, 24'd0, 2'd1);
    for (int k = 0; k < 9; k++)
      send_frame(in_beat_t'{16'(BURST_SAMPLES[k]), 16'($urandom), k == 8});

    // random settings and buffers
    base_frames = frames_sent;
    for (int phase = 0; phase < 40 && (frames_sent - base_frames < RAND_FRAMES); phase++) begin
      if (phase == 1) begin
        // dense segments while the receiver holds off: block fills and stalls
        apply_settings(11'd2, 11'd1, 31'd100000, 24'd0, 2'd2);
        hold_req = 1'b1;
        send_buffer(80);
      end else begin
        case ($urandom_range(9))
          0:       wl = 11'd0;
          1:       wl = $urandom_range(1) ? 11'd2047 : 11'd1024;
          2:       wl = LEN_CFG_W'($urandom_range(20, 64));
          default: wl = LEN_CFG_W'($urandom_range(1, 16));
        endcase
        case ($urandom_range(9))
          0:       hop = 11'd0;
          1:       hop = $urandom_range(1) ? 11'd1024 : 11'd2047;
          default: hop = LEN_CFG_W'($urandom_range(1, 8));
        endcase
        case ($urandom_range(9))
          0:       thr = 31'd0;
          1:       thr = 31'h7FFF_FFFF;
          default: thr = THR_W'($urandom_range(QUIET_MAX * QUIET_MAX + 1, LOUD_MIN * LOUD_MIN));
        endcase
        case ($urandom_range(9))
          0, 1:    ms = 24'd0;
          2:       ms = 24'hFFFFFF;
          default: ms = MIN_SIL_W'($urandom_range(1, 64));
        endcase
        ln = LANE_CFG_W'($urandom_range(3));
        apply_settings(wl, hop, thr, ms, ln);
        repeat (2)
          send_buffer(($urandom_range(9) == 0) ? $urandom_range(40, 100) : $urandom_range(2, 20));
      end
    end

    wait_idle();
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
